/* rtl/core/b64d_pkg.sv */
// Shared types and constants of the base64 stream decoder.
package b64d_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // One queue word: the results caused by one character.
    typedef struct packed {
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [1:0] nbytes;   // data bytes carried, 0..3
        logic       status;   // a status result follows the bytes
        logic       ok;       // status is success
    } grp_t;

endpackage

/* rtl/core/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder.
//
// Takes one base64 character per cycle and returns decoded bytes, then one
// status word (success or error, last_result set) after the character marked
// is_last. The front end classifies each character in the cycle it is
// accepted and pushes the results it causes into a FIFO_DEPTH-entry queue; the
// back end drains the queue one result word per cycle while out_ready allows,
// through an output register. Input is accepted every cycle while the queue
// has room, so a stream of groups of four sustains one character per cycle
// when the receiver is always ready (three bytes per four characters); a
// closing character can cause up to four results, which the queue absorbs.
// Bytes already delivered stay delivered: on an error status the consumer
// discards the bytes of that text.
module base64_stream_decoder #(
    parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last_result
);
    import b64d_pkg::*;

    grp_t push_word;
    grp_t pop_word;
    logic push;
    logic pop;
    logic not_full;
    logic not_empty;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .is_last  (is_last),
        .q_ready  (not_full),
        .q_push   (push),
        .q_word   (push_word)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_word  (pop_word)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (not_empty),
        .q_word      (pop_word),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .last_result (last_result)
    );

endmodule

/* rtl/core/b64d_front.sv */
// Front end: takes characters, tracks group position and builds queue words.
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_char,
    input  logic              is_last,
    input  logic              q_ready,
    output logic              q_push,
    output b64d_pkg::grp_t    q_word
);
    import b64d_pkg::*;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Bit 6 set means the character is outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A)
            r = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            r = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            r = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            r = 7'd62;
        else if (c == 8'h2F)
            r = 7'd63;
        return r;
    endfunction

    logic [1:0] pos_reg, pos_next;
    logic       pad_reg, pad_next;
    logic       err_reg, err_next;
    logic [5:0] group_reg [3];

    logic       fire;
    logic       is_pad;
    logic [6:0] v;
    logic       bad;
    logic       active;
    logic       wr_en;
    logic [1:0] nb;

    assign in_ready = q_ready;
    assign fire     = in_valid && in_ready;
    assign is_pad   = (in_char == PAD_CHAR);
    assign v        = sextet_of(in_char);
    assign bad      = v[6];
    assign active   = !pad_reg && !err_reg;

    always_comb
    begin
        nb       = 2'd0;
        err_next = err_reg;
        pad_next = pad_reg;
        wr_en    = 1'b0;
        if (active)
        begin
            unique case (pos_reg)
                2'd0, 2'd1:
                begin
                    if (bad)
                        err_next = 1'b1;
                    else
                        wr_en = 1'b1;
                end
                2'd2:
                begin
                    if (is_pad)
                    begin
                        nb       = 2'd1;
                        pad_next = 1'b1;
                    end
                    else if (bad)
                        err_next = 1'b1;
                    else
                        wr_en = 1'b1;
                end
                default:
                begin
                    if (is_pad)
                    begin
                        nb       = 2'd2;
                        pad_next = 1'b1;
                    end
                    else if (bad)
                        err_next = 1'b1;
                    else
                        nb = 2'd3;
                end
            endcase
        end
        pos_next = pos_reg + 2'd1;
        if (is_last)
        begin
            pos_next = 2'd0;
            pad_next = 1'b0;
        end
    end

    assign q_word.b1     = {group_reg[0], group_reg[1][5:4]};
    assign q_word.b2     = {group_reg[1][3:0], group_reg[2][5:2]};
    assign q_word.b3     = {group_reg[2][1:0], v[5:0]};
    assign q_word.nbytes = nb;
    assign q_word.status = is_last;
    assign q_word.ok     = !err_next && (pos_reg == 2'd3);
    assign q_push        = fire && ((nb != 2'd0) || is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            pad_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            err_reg <= is_last ? 1'b0 : err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
            group_reg[pos_reg] <= v[5:0];
    end

endmodule

/* rtl/core/b64d_fifo.sv */
// Short queue of result words between front and back end.
module b64d_fifo #(
    parameter int DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::grp_t    push_word,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output b64d_pkg::grp_t    pop_word
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    grp_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign not_full  = (cnt_reg != FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign pop_word  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/b64d_back.sv */
// Back end: unpacks queue words into one result word per cycle while the output is free.
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  b64d_pkg::grp_t    q_word,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic [1:0]        kind,
    output logic              last_result
);
    import b64d_pkg::*;

    grp_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] kind_reg;
    logic       last_reg;

    logic       out_free;
    logic       emit;
    logic       finish;
    logic [1:0] last_idx;
    logic [7:0] sel_byte;
    logic [1:0] sel_kind;
    logic       sel_last;

    // word always carries at least one result
    assign last_idx = 2'(3'({1'b0, cur_reg.nbytes}) + 3'(cur_reg.status) - 3'd1);
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign finish   = emit && (idx_reg == last_idx);
    assign q_pop    = q_valid && (!cur_valid_reg || finish);

    always_comb
    begin
        sel_byte = 8'd0;
        sel_kind = cur_reg.ok ? KIND_OK : KIND_ERR;
        sel_last = 1'b1;
        if (idx_reg < cur_reg.nbytes)
        begin
            sel_kind = KIND_DATA;
            sel_last = 1'b0;
            case (idx_reg)
                2'd0:    sel_byte = cur_reg.b1;
                2'd1:    sel_byte = cur_reg.b2;
                default: sel_byte = cur_reg.b3;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (finish)
                cur_valid_reg <= 1'b0;
            else if (emit)
                idx_reg <= idx_reg + 2'd1;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_word;
        if (emit)
        begin
            out_byte_reg <= sel_byte;
            kind_reg     <= sel_kind;
            last_reg     <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign kind        = kind_reg;
    assign last_result = last_reg;

endmodule

/* verif/base64_stream_decoder_tb.sv */
// Testbench of base64_stream_decoder: random base64 texts checked against a decode model.
module base64_stream_decoder_tb;

    import b64d_pkg::*;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam int         HOLD_CYCLES = 200;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } dec_word_t;

    class b64_scoreboard;
        dec_word_t expected_q[$];
        int        errors;
        bit [5:0]  sextets[3];
        bit [1:0]  pos;
        bit        pad_seen;
        bit        err_seen;

        function new();
            errors   = 0;
            pos      = 2'd0;
            pad_seen = 1'b0;
            err_seen = 1'b0;
            foreach (sextets[i]) sextets[i] = 6'd0;
        endfunction

        // bit 6 set: not in the alphabet
        function bit [6:0] sextet(bit [7:0] c);
            if (c >= "A" && c <= "Z") return {1'b0, 6'(c - 8'h41)};
            if (c >= "a" && c <= "z") return {1'b0, 6'(c - 8'h61 + 8'd26)};
            if (c >= "0" && c <= "9") return {1'b0, 6'(c - 8'h30 + 8'd52)};
            if (c == "+") return 7'd62;
            if (c == "/") return 7'd63;
            return 7'd64;
        endfunction

        function void expect_word(bit [7:0] data, bit [1:0] kind, bit last);
            dec_word_t w;
            w.data = data;
            w.kind = kind;
            w.last = last;
            expected_q.insert(expected_q.size(), w);
        endfunction

        function void note_char(bit [7:0] c, bit last);
            bit [6:0] v;
            bit [7:0] b1;
            bit [7:0] b2;
            v  = sextet(c);
            b1 = {sextets[0], sextets[1][5:4]};
            b2 = {sextets[1][3:0], sextets[2][5:2]};
            if (!pad_seen && !err_seen)
            begin
                case (pos)
                    2'd0, 2'd1:
                    begin
                        if (v[6]) err_seen = 1'b1;
                        else sextets[pos] = v[5:0];
                    end
                    2'd2:
                    begin
                        if (c == PAD_CHAR)
                        begin
                            expect_word(b1, KIND_DATA, 1'b0);
                            pad_seen = 1'b1;
                        end
                        else if (v[6]) err_seen = 1'b1;
                        else sextets[2] = v[5:0];
                    end
                    default:
                    begin
                        if (c == PAD_CHAR)
                        begin
                            expect_word(b1, KIND_DATA, 1'b0);
                            expect_word(b2, KIND_DATA, 1'b0);
                            pad_seen = 1'b1;
                        end
                        else if (v[6]) err_seen = 1'b1;
                        else
                        begin
                            expect_word(b1, KIND_DATA, 1'b0);
                            expect_word(b2, KIND_DATA, 1'b0);
                            expect_word({sextets[2][1:0], v[5:0]}, KIND_DATA, 1'b0);
                        end
                    end
                endcase
            end
            if (last)
            begin
                expect_word(8'h00, (!err_seen && pos == 2'd3) ? KIND_OK : KIND_ERR, 1'b1);
                pos      = 2'd0;
                pad_seen = 1'b0;
                err_seen = 1'b0;
            end
            else pos = pos + 2'd1;
        endfunction

        function void check_word(logic [7:0] data, logic [1:0] kind, logic last);
            dec_word_t w;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got byte %h kind %0d last %0b",
                         $time, data, kind, last);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (w.data !== data || w.kind !== kind || w.last !== last)
            begin
                $display("%0t: expected byte %h kind %0d last %0b,",
                         $time, w.data, w.kind, w.last,
                         " got byte %h kind %0d last %0b", data, kind, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_char;
    logic       is_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_result;

    b64_scoreboard sb;
    bit [7:0]      text_q[$];
    int            sent_count    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_request  = 1'b0;
    int            hold_left     = 0;

    base64_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("base64_stream_decoder: mismatch");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_word(out_byte, kind, last_result);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic bit [7:0] alpha_char(int v);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    task automatic send_char(input bit [7:0] c, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_char(c, last);
        sent_count++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic add_char(input bit [7:0] c);
        text_q.insert(text_q.size(), c);
    endtask

    task automatic send_ascii(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
        send_text();
    endtask

    // groups of alphabet chars, last group optionally padded
    task automatic build_clean_text();
        int groups;
        int pad;
        groups = $urandom_range(1, 4);
        pad    = $urandom_range(0, 2);
        text_q.delete();
        repeat (groups * 4) add_char(alpha_char($urandom_range(0, 63)));
        if (pad >= 1) text_q[groups * 4 - 1] = PAD_CHAR;
        if (pad == 2)
        begin
            text_q[groups * 4 - 2] = PAD_CHAR;
            // fourth char after '=' in position 2 goes unchecked
            if ($urandom_range(0, 3) == 0) text_q[groups * 4 - 1] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic build_broken_text();
        int g;
        build_clean_text();
        case ($urandom_range(0, 4))
            0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            1:
            begin
                g = $urandom_range(0, text_q.size() / 4 - 1);
                text_q[g * 4 + $urandom_range(0, 1)] = PAD_CHAR;
            end
            2: if (text_q.size() > 1) void'(text_q.pop_back());
            3: add_char(alpha_char($urandom_range(0, 63)));
            default: repeat (4) add_char(alpha_char($urandom_range(0, 63)));
        endcase
    endtask

    task automatic build_noise_text();
        text_q.delete();
        repeat ($urandom_range(1, 9)) add_char(8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(input int sender_pct, input int receiver_pct, input int n_chars);
        int target;
        int pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        target        = sent_count + n_chars;
        while (sent_count < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70) build_clean_text();
            else if (pick < 85) build_broken_text();
            else build_noise_text();
            send_text();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_char  <= 8'h00;
        is_last  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 66;
        send_ascii("TWFu");
        send_ascii("TQ==");
        send_ascii("TWE=");
        send_ascii("A=AA");       // pad too early
        text_q = '{"/", "/", 8'h00};
        send_text();              // foreign char, short length
        text_q = '{"T", "Q", "=", 8'hFF};
        send_text();              // unchecked fourth char
        send_ascii("A");
        drain();

        run_random(18, 66, 135);
        run_random(66, 18, 135);

        // long receiver hold-off with a steady sender fills the queue
        @(negedge clk);
        hold_request = 1'b1;
        @(posedge clk);
        run_random(0, 0, 135);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("base64_stream_decoder: match");
        end
        else
        begin
            $display("base64_stream_decoder: mismatch");
        end
        $finish;
    end

endmodule
